// ===== sv/smd_pkg.sv =====
// shared constants, codes and types of the sigma-delta motion detector
package smd_pkg;

    // frame and field geometry
    localparam int unsigned FRAME_PIXELS_DEF = 131072;
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 17;
    localparam int PIX_W      = 8;
    localparam int AMP_W      = 4;
    localparam int PROD_W     = PIX_W + AMP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int QUEUE_DEPTH = 4;

    // input modes
    localparam logic [MODE_W-1:0] MODE_INIT_PIXEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INIT_MAX   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE     = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP     = 2'd2;

    // register reset values
    localparam logic [PIX_W-1:0] VAR_MIN_RST = 8'd1;
    localparam logic [PIX_W-1:0] VAR_MAX_RST = 8'd254;
    localparam logic [AMP_W-1:0] AMP_RST     = 4'd2;

    // operations carried from front to back
    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // pixel ceiling for the saturating variance step
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] variance_min;
        logic [PIX_W-1:0] variance_max;
        logic [AMP_W-1:0] amplification;
    } cfg_t;

    // address width for a store of the given depth, at least one bit
    function automatic int idx_width(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== sv/smd_if.sv =====
// valid/ready channel interfaces for pixel input and detection results
interface smd_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [smd_pkg::MODE_W-1:0]     mode;
    logic [smd_pkg::ADDR_W-1:0]     pixel_addr;
    logic [smd_pkg::PIX_W-1:0]      pixel_value;

    modport source (output valid, output mode, output pixel_addr, output pixel_value,
                    input ready);
    modport sink   (input valid, input mode, input pixel_addr, input pixel_value,
                    output ready);
endinterface

interface smd_result_if;
    logic                           valid;
    logic                           ready;
    logic [smd_pkg::PIX_W-1:0]      difference;
    logic                           motion_flag;

    modport source (output valid, output difference, output motion_flag, input ready);
    modport sink   (input valid, input difference, input motion_flag, output ready);
endinterface

// ===== sv/sigma_delta_motion_detect_unit.sv =====
// top level of the sigma-delta motion detector: registers and block wiring
// path of an update: front stage, queue, back stage (store read), result register
// throughput: one pixel per cycle if results are taken, set by the single store ports
// the store is read as an item enters the back stage and a same-address write is bypassed
// reset: registers return to min 1, max 254, amplification 2; pipeline and queue empty
// the mean/variance store is not cleared and must be initialized per pixel
module sigma_delta_motion_detect_unit #(
    parameter int unsigned FRAME_PIXELS = smd_pkg::FRAME_PIXELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    smd_pixel_if.sink                         pixel,
    smd_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [smd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W   = smd_pkg::idx_width(FRAME_PIXELS);
    localparam int PIX_W   = smd_pkg::PIX_W;
    localparam int ENTRY_W = 1 + IDX_W + PIX_W;

    smd_pkg::cfg_t        cfg_reg;
    logic                 push, full, pop, empty;
    logic                 push_op;
    logic [IDX_W-1:0]     push_idx;
    logic [PIX_W-1:0]     push_val;
    logic [ENTRY_W-1:0]   pop_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.variance_min  <= smd_pkg::VAR_MIN_RST;
            cfg_reg.variance_max  <= smd_pkg::VAR_MAX_RST;
            cfg_reg.amplification <= smd_pkg::AMP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smd_pkg::CFG_VAR_MIN: cfg_reg.variance_min  <= cfg_data[PIX_W-1:0];
                smd_pkg::CFG_VAR_MAX: cfg_reg.variance_max  <= cfg_data[PIX_W-1:0];
                smd_pkg::CFG_AMP:     cfg_reg.amplification <= cfg_data[smd_pkg::AMP_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    smd_front #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .IDX_W        (IDX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .cfg      (cfg_reg),
        .full     (full),
        .push     (push),
        .push_op  (push_op),
        .push_idx (push_idx),
        .push_val (push_val)
    );

    smd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (smd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_op, push_idx, push_val}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    smd_back #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .IDX_W        (IDX_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (empty),
        .q_op    (pop_data[ENTRY_W-1]),
        .q_idx   (pop_data[ENTRY_W-2:PIX_W]),
        .q_val   (pop_data[PIX_W-1:0]),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== sv/smd_ram.sv =====
// generic single-write, single-read ram with registered read data
module smd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [smd_pkg::idx_width(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [smd_pkg::idx_width(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/smd_front.sv =====
// front end: accepts pixels, folds the address into the frame, classifies the operation
module smd_front #(
    parameter int unsigned FRAME_PIXELS = smd_pkg::FRAME_PIXELS_DEF,
    parameter int          IDX_W        = smd_pkg::idx_width(FRAME_PIXELS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    smd_pixel_if.sink                     pixel,
    input  smd_pkg::cfg_t                 cfg,
    input  logic                          full,
    output logic                          push,
    output logic                          push_op,
    output logic [IDX_W-1:0]              push_idx,
    output logic [smd_pkg::PIX_W-1:0]     push_val
);

    localparam int ADDR_W  = smd_pkg::ADDR_W;
    localparam int LOG_FP  = $clog2(FRAME_PIXELS);
    localparam int SHIFT   = ADDR_W + LOG_FP;
    localparam int RECIP_W = ADDR_W + 2;
    localparam int FP_W    = $clog2(FRAME_PIXELS + 1);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
    localparam logic [FP_W-1:0]    FP_CONST = FP_W'(FRAME_PIXELS);

    logic                      accept;
    logic                      mode_ok;
    logic [ADDR_W+RECIP_W-1:0] quot_prod;
    logic [ADDR_W-1:0]         quot;
    logic [ADDR_W+FP_W-1:0]    back_prod;
    logic [ADDR_W-1:0]         rem;

    logic                      f1_valid_reg, f1_valid_next;
    logic                      f1_op_reg;
    logic [ADDR_W-1:0]         f1_addr_reg;
    logic [ADDR_W-1:0]         f1_quot_reg;
    logic [smd_pkg::PIX_W-1:0] f1_val_reg;

    // input handshake: the stage empties into the queue
    assign push         = f1_valid_reg && !full;
    assign pixel.ready  = !f1_valid_reg || !full;
    assign accept       = pixel.valid && pixel.ready;
    assign mode_ok      = (pixel.mode == smd_pkg::MODE_INIT_PIXEL) ||
                          (pixel.mode == smd_pkg::MODE_INIT_MAX) ||
                          (pixel.mode == smd_pkg::MODE_UPDATE);

    // quotient by reciprocal multiplication
    assign quot_prod = (ADDR_W+RECIP_W)'(pixel.pixel_addr) * (ADDR_W+RECIP_W)'(RECIP);
    assign quot      = ADDR_W'(quot_prod >> SHIFT);

    assign f1_valid_next = (accept && mode_ok) || (f1_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    // stage payload, resolves init values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_addr_reg <= pixel.pixel_addr;
            f1_quot_reg <= quot;
            case (pixel.mode)
                smd_pkg::MODE_INIT_PIXEL:
                begin
                    f1_op_reg  <= smd_pkg::OP_INIT;
                    f1_val_reg <= pixel.pixel_value;
                end
                smd_pkg::MODE_INIT_MAX:
                begin
                    f1_op_reg  <= smd_pkg::OP_INIT;
                    f1_val_reg <= cfg.variance_max;
                end
                default:
                begin
                    f1_op_reg  <= smd_pkg::OP_UPDATE;
                    f1_val_reg <= pixel.pixel_value;
                end
            endcase
        end
    end

    // remainder from the registered quotient
    assign back_prod = (ADDR_W+FP_W)'(f1_quot_reg) * (ADDR_W+FP_W)'(FP_CONST);
    assign rem       = f1_addr_reg - ADDR_W'(back_prod);

    assign push_op  = f1_op_reg;
    assign push_idx = IDX_W'(rem);
    assign push_val = f1_val_reg;

endmodule

// ===== sv/smd_queue.sv =====
// short register queue between front and back
module smd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = smd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = smd_pkg::idx_width(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FULLC);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/smd_back.sv =====
// back end: read-modify-write of mean and variance, result register
module smd_back #(
    parameter int unsigned FRAME_PIXELS = smd_pkg::FRAME_PIXELS_DEF,
    parameter int          IDX_W        = smd_pkg::idx_width(FRAME_PIXELS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smd_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  logic                          q_op,
    input  logic [IDX_W-1:0]              q_idx,
    input  logic [smd_pkg::PIX_W-1:0]     q_val,
    output logic                          pop,
    smd_result_if.source                  result
);

    localparam int PIX_W  = smd_pkg::PIX_W;
    localparam int PROD_W = smd_pkg::PROD_W;
    localparam int ENT_W  = 2 * PIX_W;

    logic                 issue;
    logic                 b_fire;
    logic                 out_open;
    logic [ENT_W-1:0]     ram_rdata;
    logic [ENT_W-1:0]     entry;
    logic [ENT_W-1:0]     wr_data;
    logic [PIX_W-1:0]     mean_old, mean_new, var_old, var_step, var_clamp, diff;
    logic [PROD_W-1:0]    target;
    logic                 motion;

    logic                 b_valid_reg, b_valid_next;
    logic                 b_op_reg;
    logic [IDX_W-1:0]     b_idx_reg;
    logic [PIX_W-1:0]     b_val_reg;
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [ENT_W-1:0]     fwd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     out_diff_reg;
    logic                 out_flag_reg;

    // stage advance
    assign out_open = !out_valid_reg || result.ready;
    assign b_fire   = b_valid_reg && ((b_op_reg == smd_pkg::OP_INIT) || out_open);
    assign issue    = !q_empty && (!b_valid_reg || b_fire);
    assign pop      = issue;

    // per-pixel background store, mean in the upper byte
    smd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FRAME_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (b_fire),
        .waddr (b_idx_reg),
        .wdata (wr_data),
        .re    (issue),
        .raddr (q_idx),
        .rdata (ram_rdata)
    );

    // bypass of a write that landed in the read cycle
    assign entry    = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign mean_old = entry[ENT_W-1:PIX_W];
    assign var_old  = entry[PIX_W-1:0];

    // mean step and absolute difference
    always_comb
    begin
        if (mean_old < b_val_reg)
        begin
            mean_new = mean_old + 1'b1;
        end
        else if (mean_old > b_val_reg)
        begin
            mean_new = mean_old - 1'b1;
        end
        else
        begin
            mean_new = mean_old;
        end
        diff = (mean_new > b_val_reg) ? (mean_new - b_val_reg) : (b_val_reg - mean_new);
    end

    assign target = PROD_W'(cfg.amplification) * PROD_W'(diff);

    // saturating variance step, then clamp with min winning
    always_comb
    begin
        var_step = var_old;
        if (PROD_W'(var_old) < target)
        begin
            if (var_old != smd_pkg::PIX_MAX)
            begin
                var_step = var_old + 1'b1;
            end
        end
        else if (PROD_W'(var_old) > target)
        begin
            if (var_old != '0)
            begin
                var_step = var_old - 1'b1;
            end
        end
        var_clamp = var_step;
        if (var_clamp > cfg.variance_max)
        begin
            var_clamp = cfg.variance_max;
        end
        if (var_clamp < cfg.variance_min)
        begin
            var_clamp = cfg.variance_min;
        end
    end

    assign motion  = (diff >= var_clamp);
    assign wr_data = (b_op_reg == smd_pkg::OP_INIT) ? {b_val_reg, cfg.variance_min}
                                                    : {mean_new, var_clamp};

    // control state
    assign b_valid_next   = issue || (b_valid_reg && !b_fire);
    assign fwd_valid_next = issue ? (b_fire && (b_idx_reg == q_idx))
                                  : (fwd_valid_reg && !b_fire);
    assign out_valid_next = (b_fire && (b_op_reg == smd_pkg::OP_UPDATE)) ||
                            (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_op_reg     <= q_op;
            b_idx_reg    <= q_idx;
            b_val_reg    <= q_val;
            fwd_data_reg <= wr_data;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (b_fire && (b_op_reg == smd_pkg::OP_UPDATE))
        begin
            out_diff_reg <= diff;
            out_flag_reg <= motion;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.difference  = out_diff_reg;
    assign result.motion_flag = out_flag_reg;

    // checks
    a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && (b_op_reg == smd_pkg::OP_UPDATE)) |=> out_valid_reg)
        else $error("update transaction did not reach the result register");

    a_bypass_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> b_valid_reg)
        else $error("bypass flagged with no item in the stage");

    a_stalled_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_fire) |=> (b_valid_reg && $stable(b_idx_reg)))
        else $error("stalled item changed");

    a_full_output_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && (b_op_reg == smd_pkg::OP_UPDATE)) |-> !b_fire)
        else $error("update overwrote a waiting result");

endmodule
